[sv/rpn_pkg.sv]
// ----------------------------------------------------------------------------
// RPN evaluator package
// Shared token codes, status codes and the divider request and response structs.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam logic [1:0] KIND_PUSH   = 2'd0;
  localparam logic [1:0] KIND_UNARY  = 2'd1;
  localparam logic [1:0] KIND_BINARY = 2'd2;

  localparam logic [4:0] UOP_PLUS   = 5'd0;
  localparam logic [4:0] UOP_NEG    = 5'd1;
  localparam logic [4:0] UOP_LNOT   = 5'd2;
  localparam logic [4:0] UOP_BNOT   = 5'd3;

  localparam logic [4:0] BOP_MUL  = 5'd0;
  localparam logic [4:0] BOP_DIV  = 5'd1;
  localparam logic [4:0] BOP_REM  = 5'd2;
  localparam logic [4:0] BOP_ADD  = 5'd3;
  localparam logic [4:0] BOP_SUB  = 5'd4;
  localparam logic [4:0] BOP_SHR  = 5'd5;
  localparam logic [4:0] BOP_SHL  = 5'd6;
  localparam logic [4:0] BOP_LT   = 5'd7;
  localparam logic [4:0] BOP_GT   = 5'd8;
  localparam logic [4:0] BOP_LE   = 5'd9;
  localparam logic [4:0] BOP_GE   = 5'd10;
  localparam logic [4:0] BOP_EQ   = 5'd11;
  localparam logic [4:0] BOP_NE   = 5'd12;
  localparam logic [4:0] BOP_AND  = 5'd13;
  localparam logic [4:0] BOP_OR   = 5'd14;
  localparam logic [4:0] BOP_XOR  = 5'd15;
  localparam logic [4:0] BOP_LAND = 5'd16;
  localparam logic [4:0] BOP_LOR  = 5'd17;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_STACK = 2'd1;
  localparam logic [1:0] ST_DIV0  = 2'd2;

  typedef struct packed {
    logic        start;
    logic        want_rem;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } div_rsp_t;

endpackage

[sv/rpn_div.sv]
// ----------------------------------------------------------------------------
// RPN signed divider
// Radix-2 restoring divider, one quotient bit per cycle, signed fix-up last.
// ----------------------------------------------------------------------------
module rpn_div import rpn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [63:0] quo_q, quo_d;
  logic [63:0] rem_q, rem_d;
  logic [63:0] den_q, den_d;
  logic        neg_q_q, neg_q_d;
  logic        neg_r_q, neg_r_d;
  logic        rem_sel_q, rem_sel_d;
  logic        done_q, done_d;
  logic [63:0] res_q, res_d;
  logic [64:0] trial;
  logic [63:0] shifted;

  always_comb begin
    busy_d    = busy_q;
    cnt_d     = cnt_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    den_d     = den_q;
    neg_q_d   = neg_q_q;
    neg_r_d   = neg_r_q;
    rem_sel_d = rem_sel_q;
    done_d    = 1'b0;
    res_d     = res_q;
    shifted   = {rem_q[62:0], quo_q[63]};
    trial     = {1'b0, shifted} - {1'b0, den_q};
    if (req_i.start) begin
      busy_d    = 1'b1;
      cnt_d     = 7'd0;
      quo_d     = req_i.num[63] ? 64'd0 - req_i.num : req_i.num;
      den_d     = req_i.den[63] ? 64'd0 - req_i.den : req_i.den;
      rem_d     = 64'd0;
      neg_q_d   = req_i.num[63] ^ req_i.den[63];
      neg_r_d   = req_i.num[63];
      rem_sel_d = req_i.want_rem;
    end else if (busy_q) begin
      // The remainder can exceed 63 bits only transiently, so compare in 65 bits.
      if (rem_q[63] || !trial[64]) begin
        rem_d = shifted - den_q;
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (rem_sel_q) begin
          res_d = neg_r_q ? 64'd0 - rem_d : rem_d;
        end else begin
          res_d = neg_q_q ? 64'd0 - quo_d : quo_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 7'd0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    den_q     <= den_d;
    neg_q_q   <= neg_q_d;
    neg_r_q   <= neg_r_d;
    rem_sel_q <= rem_sel_d;
    res_q     <= res_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

endmodule

[sv/rpn_stack_evaluator.sv]
// ----------------------------------------------------------------------------
// RPN stack evaluator
// Postfix token evaluator on a bounded stack of signed 64-bit values.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata fields (low bit up)           tuser / tlast
// s_axis    in   kind[1:0], op_code[6:2], value[70:7] tlast = last token
// m_axis    out  result_value[63:0], status[65:64]     none
//
// A unary token passes S_RDB and S_EXEC, a binary token S_RDB, S_RDA (two
// memory reads) and S_EXEC; multiply adds S_MUL (three 32x32 partial products),
// divide and remainder add S_DIV (radix-2 divider), a divide by zero skips
// S_EXEC. A last token adds S_FIN and S_FIN2 to read the bottom entry and load
// the output register. Reset clears the count and error; the stack memory is
// not cleared. A last token waits in S_FIN2 only while the previous result is unaccepted.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator import rpn_pkg::*; #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // kind, op_code, operand_value, pad
  input  logic        s_axis_tlast,   // last_token
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // result_value, status, pad
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDB   = 3'd1;
  localparam logic [2:0] S_RDA   = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;
  localparam logic [2:0] S_FIN2  = 3'd7;

  logic [63:0] mem [STACK_DEPTH];
  logic [63:0] rdata_q;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0] wdata;

  logic [2:0]  st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [1:0]  err_q, err_d;
  logic [1:0]  kind_q, kind_d;
  logic [4:0]  op_q, op_d;
  logic        last_q, last_d;
  logic [63:0] b_q, b_d;
  logic [63:0] a_q, a_d;
  logic [63:0] prod_q, prod_d;
  logic [1:0]  mstep_q, mstep_d;
  logic        ov_q, ov_d;
  logic [65:0] out_q, out_d;
  div_req_t    dreq;
  div_rsp_t    drsp;

  logic        take;
  logic [1:0]  in_kind;
  logic [4:0]  in_op;
  logic [63:0] in_val;
  logic        lt_ab, lt_ba;
  logic [63:0] res;
  logic [31:0] mul_x, mul_y;
  logic [63:0] mul_p;

  assign in_kind = s_axis_tdata[1:0];
  assign in_op   = s_axis_tdata[6:2];
  assign in_val  = s_axis_tdata[70:7];
  assign s_axis_tready = (st_q == S_IDLE);
  assign take = s_axis_tvalid && s_axis_tready;

  rpn_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // The low 64 bits of the product are built from three 32x32 partial products.
  always_comb begin
    case (mstep_q)
      2'd0: begin
        mul_x = a_q[31:0];
        mul_y = b_q[31:0];
      end
      2'd1: begin
        mul_x = a_q[31:0];
        mul_y = b_q[63:32];
      end
      default: begin
        mul_x = a_q[63:32];
        mul_y = b_q[31:0];
      end
    endcase
  end

  assign mul_p = 64'(mul_x) * 64'(mul_y);

  assign lt_ab = $signed(a_q) < $signed(b_q);
  assign lt_ba = $signed(b_q) < $signed(a_q);

  always_comb begin
    res = 64'd0;
    if (kind_q == KIND_UNARY) begin
      case (op_q)
        UOP_PLUS: res = b_q;
        UOP_NEG:  res = 64'd0 - b_q;
        UOP_LNOT: res = {63'd0, b_q == 64'd0};
        default:  res = ~b_q;
      endcase
    end else begin
      case (op_q)
        BOP_ADD:  res = a_q + b_q;
        BOP_SUB:  res = a_q - b_q;
        BOP_SHR:  res = 64'($signed(a_q) >>> b_q[5:0]);
        BOP_SHL:  res = a_q << b_q[5:0];
        BOP_LT:   res = {63'd0, lt_ab};
        BOP_GT:   res = {63'd0, lt_ba};
        BOP_LE:   res = {63'd0, !lt_ba};
        BOP_GE:   res = {63'd0, !lt_ab};
        BOP_EQ:   res = {63'd0, a_q == b_q};
        BOP_NE:   res = {63'd0, a_q != b_q};
        BOP_AND:  res = a_q & b_q;
        BOP_OR:   res = a_q | b_q;
        BOP_XOR:  res = a_q ^ b_q;
        BOP_LAND: res = {63'd0, (a_q != 64'd0) && (b_q != 64'd0)};
        BOP_LOR:  res = {63'd0, (a_q != 64'd0) || (b_q != 64'd0)};
        default:  res = prod_q;
      endcase
    end
  end

  always_comb begin
    st_d    = st_q;
    cnt_d   = cnt_q;
    err_d   = err_q;
    kind_d  = kind_q;
    op_d    = op_q;
    last_d  = last_q;
    b_d     = b_q;
    a_d     = a_q;
    prod_d  = prod_q;
    mstep_d = mstep_q;
    ov_d    = ov_q;
    out_d   = out_q;
    we      = 1'b0;
    waddr   = AW'(cnt_q - CW'(1));
    wdata   = res;
    raddr   = AW'(cnt_q - CW'(1));
    dreq.start    = 1'b0;
    dreq.want_rem = (op_q == BOP_REM);
    dreq.num      = a_q;
    dreq.den      = b_q;
    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end
    case (st_q)
      S_IDLE: begin
        if (take) begin
          kind_d = in_kind;
          op_d   = in_op;
          last_d = s_axis_tlast;
          st_d   = s_axis_tlast ? S_FIN : S_IDLE;
          if (err_q == ST_OK) begin
            if (in_kind == KIND_PUSH) begin
              if (cnt_q >= CW'(STACK_DEPTH)) begin
                err_d = ST_STACK;
              end else begin
                we    = 1'b1;
                waddr = AW'(cnt_q);
                wdata = in_val;
                cnt_d = cnt_q + CW'(1);
              end
            end else if (in_kind == KIND_UNARY && in_op <= UOP_BNOT) begin
              if (cnt_q == CW'(0)) begin
                err_d = ST_STACK;
              end else begin
                st_d = S_RDB;
              end
            end else if (in_kind == KIND_BINARY && in_op <= BOP_LOR) begin
              if (cnt_q < CW'(2)) begin
                err_d = ST_STACK;
              end else begin
                st_d = S_RDB;
              end
            end
          end
        end
      end
      S_RDB: begin
        // Read address of the top entry was presented in the accept cycle.
        b_d   = rdata_q;
        raddr = AW'(cnt_q - CW'(2));
        if (kind_q == KIND_UNARY) begin
          st_d = S_EXEC;
        end else begin
          st_d = S_RDA;
        end
      end
      S_RDA: begin
        a_d  = rdata_q;
        st_d = S_EXEC;
        if ((op_q == BOP_DIV || op_q == BOP_REM)) begin
          if (b_q == 64'd0) begin
            err_d = ST_DIV0;
            st_d  = last_q ? S_FIN : S_IDLE;
          end else begin
            dreq.start = 1'b1;
            dreq.num   = rdata_q;
            st_d       = S_DIV;
          end
        end else if (op_q == BOP_MUL) begin
          mstep_d = 2'd0;
          st_d    = S_MUL;
        end
      end
      S_MUL: begin
        mstep_d = mstep_q + 2'd1;
        if (mstep_q == 2'd0) begin
          prod_d = mul_p;
        end else begin
          prod_d = prod_q + {mul_p[31:0], 32'd0};
        end
        if (mstep_q == 2'd2) begin
          st_d = S_EXEC;
        end
      end
      S_DIV: begin
        if (drsp.done) begin
          prod_d = drsp.res;
          st_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        we = 1'b1;
        if (kind_q == KIND_BINARY) begin
          waddr = AW'(cnt_q - CW'(2));
          cnt_d = cnt_q - CW'(1);
        end
        st_d = last_q ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        raddr = AW'(0);
        st_d  = S_FIN2;
      end
      S_FIN2: begin
        if (!ov_q || m_axis_tready) begin
          if (err_q == ST_OK && cnt_q == CW'(1)) begin
            out_d = {ST_OK, rdata_q};
          end else if (err_q == ST_OK) begin
            out_d = {ST_STACK, 64'd0};
          end else begin
            out_d = {err_q, 64'd0};
          end
          ov_d  = 1'b1;
          cnt_d = '0;
          err_d = ST_OK;
          st_d  = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      cnt_q <= '0;
      err_q <= ST_OK;
      ov_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      err_q <= err_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    op_q    <= op_d;
    last_q  <= last_d;
    b_q     <= b_d;
    a_q     <= a_d;
    prod_q  <= prod_d;
    mstep_q <= mstep_d;
    out_q   <= out_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {6'd0, out_q};

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(STACK_DEPTH)) else $error("stack count beyond depth");
  a_out_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && out_q[65:64] != ST_OK |-> out_q[63:0] == 64'd0)
    else $error("error result carries a value");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> cnt_q == '0 && err_q == ST_OK)
    else $error("state not cleared after result");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != S_IDLE |-> !s_axis_tready) else $error("ready while busy");

endmodule
